FILE: src/slh_pkg.sv
package slh_pkg;

    localparam int MAX_BINS    = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int STORE_DEPTH = MAX_BINS + 2;

    localparam int SAMPLE_W    = 24;
    localparam int NBINS_W     = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int OUT_INDEX_W = 6;
    localparam int OUT_COUNT_W = 16;

    localparam int BIN_W  = $clog2(STORE_DEPTH);
    localparam int N_W    = $clog2(MAX_BINS + 1);
    localparam int PROD_W = SAMPLE_W + N_W;
    localparam int STEP_W = $clog2(N_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOW_EDGE,
        CFG_HIGH_EDGE,
        CFG_BINS_IN_USE
    } cfg_reg_t;

    typedef struct packed {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_start;
    } cmd_t;

    typedef struct packed {
        logic [OUT_INDEX_W-1:0] bin_index;
        logic [OUT_COUNT_W-1:0] bin_count;
        logic                   last;
    } result_t;

    typedef enum logic [1:0] {
        OP_DIRECT,
        OP_DIVIDE,
        OP_DUMP
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                clear;
        logic [BIN_W-1:0]    bin;
        logic [SAMPLE_W-1:0] off;
        logic [SAMPLE_W-1:0] span;
        logic [N_W-1:0]      n;
    } item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_READ,
        S_WRITE,
        S_DREAD,
        S_DOUT
    } back_state_t;

    function automatic logic [OUT_COUNT_W-1:0] out_count(input logic [COUNT_WIDTH-1:0] c);
        if ((COUNT_WIDTH > OUT_COUNT_W) && ((c >> OUT_COUNT_W) != '0))
            return '1;
        else
            return OUT_COUNT_W'(c);
    endfunction

endpackage

FILE: src/slh_ram.sv
module slh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 34
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/slh_front.sv
module slh_front import slh_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   start,
    input  cmd_t                   cmd,
    input  logic                   full,
    output logic                   busy,
    output logic                   push,
    output item_t                  push_item
);

    logic signed [SAMPLE_W-1:0] low_reg;
    logic signed [SAMPLE_W-1:0] high_reg;
    logic [NBINS_W-1:0]         bins_reg;

    logic [N_W-1:0]      n_eff;
    logic [SAMPLE_W:0]   off_full;
    logic [SAMPLE_W:0]   span_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            high_reg <= {1'b0, {(SAMPLE_W-1){1'b1}}};
            bins_reg <= NBINS_W'(MAX_BINS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOW_EDGE:    low_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_HIGH_EDGE:   high_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_BINS_IN_USE: bins_reg <= cfg_data[NBINS_W-1:0];
                default:         ;
            endcase
        end
    end

    // clamp the bin count into 1..MAX_BINS
    always_comb
    begin
        if (bins_reg == '0)
            n_eff = N_W'(1);
        else if (bins_reg > NBINS_W'(MAX_BINS))
            n_eff = N_W'(MAX_BINS);
        else
            n_eff = N_W'(bins_reg);
    end

    assign off_full  = {cmd.sample[SAMPLE_W-1], cmd.sample} - {low_reg[SAMPLE_W-1], low_reg};
    assign span_full = {high_reg[SAMPLE_W-1], high_reg} - {low_reg[SAMPLE_W-1], low_reg};

    assign busy = full;
    assign push = start && !full;

    always_comb
    begin
        push_item.clear = !cmd.func && cmd.block_start;
        push_item.off   = off_full[SAMPLE_W-1:0];
        push_item.span  = span_full[SAMPLE_W-1:0];
        push_item.n     = n_eff;
        push_item.bin   = '0;
        if (cmd.func)
        begin
            push_item.op = OP_DUMP;
        end
        else if (cmd.sample < low_reg)
        begin
            push_item.op = OP_DIRECT;
        end
        else if (cmd.sample > high_reg)
        begin
            push_item.op  = OP_DIRECT;
            push_item.bin = BIN_W'(n_eff) + BIN_W'(1);
        end
        else if (high_reg == low_reg)
        begin
            push_item.op  = OP_DIRECT;
            push_item.bin = BIN_W'(1);
        end
        else
        begin
            push_item.op = OP_DIVIDE;
        end
    end

endmodule

FILE: src/slh_queue.sv
module slh_queue import slh_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  empty
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: src/slh_back.sv
module slh_back import slh_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   head,
    input  logic    empty,
    output logic    pop,
    output logic    strobe,
    output result_t result
);

    back_state_t state_reg, state_next;

    item_t              item_reg, item_next;
    logic [PROD_W-1:0]  rem_reg, rem_next;
    logic [N_W-1:0]     q_reg, q_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic               valid_reg [STORE_DEPTH];
    logic               valid_next [STORE_DEPTH];
    logic               strobe_reg, strobe_next;
    result_t            result_reg, result_next;

    logic [PROD_W:0]          trial;
    logic [N_W-1:0]           q_shift;
    logic [N_W:0]             q_plus;
    logic                     dump_last;
    logic [COUNT_WIDTH-1:0]   old_count;

    logic                     ram_we;
    logic                     ram_re;
    logic [COUNT_WIDTH-1:0]   ram_wdata;
    logic [COUNT_WIDTH-1:0]   ram_rdata;

    slh_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(STORE_DEPTH)
    ) u_slh_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bin_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (bin_reg),
        .rdata (ram_rdata)
    );

    // one restoring step, quotient bit MSB first
    assign trial   = {1'b0, rem_reg} - {1'b0, PROD_W'(item_reg.span) << step_reg};
    assign q_shift = (q_reg << 1) | N_W'(!trial[PROD_W]);
    assign q_plus  = (N_W+1)'(q_shift) + (N_W+1)'(1);

    assign dump_last = (bin_reg == BIN_W'(item_reg.n) + BIN_W'(1));
    assign old_count = valid_reg[bin_reg] ? ram_rdata : '0;
    assign ram_wdata = (old_count == '1) ? old_count : old_count + COUNT_WIDTH'(1);

    assign strobe = strobe_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    unique case (head.op)
                        OP_DUMP:   state_next = S_DREAD;
                        OP_DIVIDE: state_next = S_MUL;
                        default:   state_next = S_READ;
                    endcase
                end
            end
            S_MUL:   state_next = S_DIV;
            S_DIV:   state_next = (step_reg == '0) ? S_READ : S_DIV;
            S_READ:  state_next = S_WRITE;
            S_WRITE: state_next = S_IDLE;
            S_DREAD: state_next = S_DOUT;
            S_DOUT:  state_next = dump_last ? S_IDLE : S_DREAD;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        item_next   = item_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        step_next   = step_reg;
        bin_next    = bin_reg;
        valid_next  = valid_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    item_next = head;
                    bin_next  = (head.op == OP_DUMP) ? '0 : head.bin;
                    // drop the whole store at once
                    if (head.clear)
                    begin
                        valid_next = '{default: 1'b0};
                    end
                end
            end
            S_MUL:
            begin
                rem_next  = PROD_W'(item_reg.off) * PROD_W'(item_reg.n);
                q_next    = '0;
                step_next = STEP_W'(N_W - 1);
            end
            S_DIV:
            begin
                if (!trial[PROD_W])
                begin
                    rem_next = trial[PROD_W-1:0];
                end
                q_next    = q_shift;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    bin_next = (q_plus > (N_W+1)'(item_reg.n)) ? BIN_W'(item_reg.n)
                                                               : BIN_W'(q_plus);
                end
            end
            S_READ:
            begin
                ram_re = 1'b1;
            end
            S_WRITE:
            begin
                ram_we              = 1'b1;
                valid_next[bin_reg] = 1'b1;
            end
            S_DREAD:
            begin
                ram_re = 1'b1;
            end
            S_DOUT:
            begin
                strobe_next           = 1'b1;
                result_next.bin_index = OUT_INDEX_W'(bin_reg);
                result_next.bin_count = out_count(old_count);
                result_next.last      = dump_last;
                bin_next              = bin_reg + BIN_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '{default: 1'b0};
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        step_reg   <= step_next;
        bin_reg    <= bin_next;
        result_reg <= result_next;
    end

endmodule

FILE: src/sample_level_histogram.sv
// Counting a sample holds the back end through pop, multiply, a 6-step divide,
// then a read and a write of the counter RAM; a sample off the edges, or with
// equal edges, skips the multiply and divide. A dump emits each word by a RAM
// read, then the output register, and gives clamped bins_in_use+2 words.
// A 2-entry queue takes start while the back end works; busy means it is full.
// Reset clears all counters at once and loads the edge and bin-count defaults.
module sample_level_histogram import slh_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   start,
    input  cmd_t                   cmd,
    output logic                   busy,
    output logic                   strobe,
    output result_t                result
);

    logic  push;
    item_t push_item;
    logic  full;
    logic  pop;
    item_t head;
    logic  empty;

    slh_front u_slh_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .cmd       (cmd),
        .full      (full),
        .busy      (busy),
        .push      (push),
        .push_item (push_item)
    );

    slh_queue u_slh_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    slh_back u_slh_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

FILE: src/slh_checker.sv
module slh_sva_checker import slh_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    busy,
    input logic    strobe,
    input result_t result
);

    // dump words never come back to back
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("dump words back to back");

    // a dump walks the bins in order without gaps
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> ##2 (strobe &&
            result.bin_index == OUT_INDEX_W'($past(result.bin_index, 2) + 1)))
        else $error("dump bin index did not advance by one");

    // the last word is the overflow bin of a legal bin count
    a_last_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last |->
            result.bin_index >= OUT_INDEX_W'(2) &&
            result.bin_index <= OUT_INDEX_W'(MAX_BINS + 1))
        else $error("last flag on an impossible bin");

    // out of reset the block is empty and quiet
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !busy && !strobe)
        else $error("busy or strobe right after reset");

endmodule

bind sample_level_histogram slh_sva_checker u_slh_sva_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

FILE: dv/slh_checker.sv
module slh_checker import slh_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   start,
    input  cmd_t                   cmd,
    input  logic                   busy,
    input  logic                   strobe,
    input  result_t                result,
    output int                     errors,
    output int                     pending,
    output int                     words_seen
);

    localparam int MAX_PRINTED = 40;

    logic signed [SAMPLE_W-1:0] low_edge;
    logic signed [SAMPLE_W-1:0] high_edge;
    logic [NBINS_W-1:0]         bins_reg;
    logic [COUNT_WIDTH-1:0]     tally [STORE_DEPTH];
    result_t                    expected_words [$];

    function automatic int unsigned active_bins();
        if (bins_reg == 0)
        begin
            return 1;
        end
        if (bins_reg > MAX_BINS)
        begin
            return MAX_BINS;
        end
        return bins_reg;
    endfunction

    function automatic int unsigned bin_of(input logic signed [SAMPLE_W-1:0] x);
        longint            lo;
        longint            hi;
        longint            xs;
        longint unsigned   off;
        longint unsigned   span;
        longint unsigned   q;
        int unsigned       n;
        n  = active_bins();
        lo = low_edge;
        hi = high_edge;
        xs = x;
        if (xs < lo)
        begin
            return 0;
        end
        if (xs > hi)
        begin
            return n + 1;
        end
        off  = xs - lo;
        span = hi - lo;
        if (span == 0)
        begin
            return 1;
        end
        q = (off * n) / span;
        // clamp the top edge into the last in-range bin
        if (q + 1 > n)
        begin
            return n;
        end
        return int'(q) + 1;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < MAX_PRINTED)
        begin
            $display("%0t histogram mismatch: %s", $time, what);
        end
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned n;
        int unsigned b;
        result_t     w;
        if (!rst_n)
        begin
            low_edge   = 24'sh800000;
            high_edge  = 24'sh7FFFFF;
            bins_reg   = NBINS_W'(MAX_BINS);
            foreach (tally[i])
            begin
                tally[i] = '0;
            end
            expected_words.delete();
            errors     = 0;
            pending    = 0;
            words_seen = 0;
        end
        else
        begin
            if (strobe)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("word for bin %0d with no dump pending",
                                              result.bin_index));
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (result.bin_index !== w.bin_index)
                    begin
                        report_mismatch($sformatf("bin_index got %0d want %0d",
                                                  result.bin_index, w.bin_index));
                    end
                    if (result.bin_count !== w.bin_count)
                    begin
                        report_mismatch($sformatf("bin %0d bin_count got %0d want %0d",
                                                  w.bin_index, result.bin_count,
                                                  w.bin_count));
                    end
                    if (result.last !== w.last)
                    begin
                        report_mismatch($sformatf("bin %0d last got %b want %b",
                                                  w.bin_index, result.last, w.last));
                    end
                end
            end

            if (start && !busy)
            begin
                n = active_bins();
                if (cmd.func)
                begin
                    // block_start has no effect on a dump
                    for (int unsigned i = 0; i <= n + 1; i++)
                    begin
                        w.bin_index = OUT_INDEX_W'(i);
                        w.bin_count = (32'(tally[i]) > 32'hFFFF) ? '1
                                                                 : OUT_COUNT_W'(tally[i]);
                        w.last      = (i == n + 1);
                        expected_words.push_back(w);
                    end
                end
                else
                begin
                    if (cmd.block_start)
                    begin
                        foreach (tally[i])
                        begin
                            tally[i] = '0;
                        end
                    end
                    b = bin_of(cmd.sample);
                    // hold at full scale
                    if (tally[b] != '1)
                    begin
                        tally[b] = tally[b] + 1'b1;
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOW_EDGE:    low_edge  = cfg_data[SAMPLE_W-1:0];
                    CFG_HIGH_EDGE:   high_edge = cfg_data[SAMPLE_W-1:0];
                    CFG_BINS_IN_USE: bins_reg  = cfg_data[NBINS_W-1:0];
                    default:         ;
                endcase
            end

            pending = expected_words.size();
        end
    end

endmodule

FILE: dv/testbench.sv
module testbench;
    import slh_pkg::*;

    localparam int SETTLE      = 40;
    localparam int STALL_LIMIT = 2000;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   start     = 1'b0;
    cmd_t                   cmd       = '0;
    logic                   busy;
    logic                   strobe;
    result_t                result;

    int errors;
    int pending;
    int words_seen;
    int items_sent    = 0;
    int dumps_sent    = 0;
    int settings_used = 0;
    bit gapless       = 1'b0;

    logic signed [SAMPLE_W-1:0] cur_low  = 24'sh800000;
    logic signed [SAMPLE_W-1:0] cur_high = 24'sh7FFFFF;

    sample_level_histogram u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .strobe    (strobe),
        .result    (result)
    );

    slh_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .strobe     (strobe),
        .result     (result),
        .errors     (errors),
        .pending    (pending),
        .words_seen (words_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // start stays high between back-to-back words; lower it only ahead of a gap
    task automatic issue(input logic f, input logic [SAMPLE_W-1:0] x, input logic bs);
        cmd_t c;
        int   gap;
        c.func        = f;
        c.sample      = x;
        c.block_start = bs;
        gap = gapless ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        items_sent++;
        if (f)
        begin
            dumps_sent++;
        end
    endtask

    // wait out every pending dump word, then the count pipeline
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_levels(input logic signed [SAMPLE_W-1:0] lo,
                              input logic signed [SAMPLE_W-1:0] hi,
                              input logic [NBINS_W-1:0] n);
        cur_low  = lo;
        cur_high = hi;
        settings_used++;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOW_EDGE;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_HIGH_EDGE;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_BINS_IN_USE;
        cfg_data  <= {18'($urandom), n};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_levels();
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic signed [SAMPLE_W-1:0] t;
        a = SAMPLE_W'($urandom);
        b = SAMPLE_W'($urandom);
        case ($urandom_range(0, 3))
            0: ;
            1: b = a + SAMPLE_W'($urandom_range(0, 64));
            2: b = a;
            default:
            begin
                if (a > b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
        endcase
        set_levels(a, b, NBINS_W'($urandom_range(0, 63)));
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        longint lo;
        longint hi;
        longint span;
        lo = cur_low;
        hi = cur_high;
        case ($urandom_range(0, 5))
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'(lo + longint'($urandom_range(0, 4)) - 2);
            2: return SAMPLE_W'(hi + longint'($urandom_range(0, 4)) - 2);
            5: return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
            default:
            begin
                span = hi - lo;
                if (span < 0)
                begin
                    return SAMPLE_W'($urandom);
                end
                return SAMPLE_W'(lo + longint'($urandom) % (span + 1));
            end
        endcase
    endfunction

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || strobe || cfg_we)
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("sample_level_histogram verification failed");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset levels: full scale, 32 bins
        issue(1'b0, 24'h800000, 1'b0);
        issue(1'b0, 24'h7FFFFF, 1'b0);
        issue(1'b0, 24'h000000, 1'b0);
        issue(1'b1, 24'h5A5A5A, 1'b1);
        drain();

        // single in-range bin, both edges and one step outside each
        set_levels(-24'sd1000, 24'sd1000, 6'd1);
        issue(1'b0, -24'sd1001, 1'b0);
        issue(1'b0, -24'sd1000, 1'b0);
        issue(1'b0, 24'sd1000, 1'b0);
        issue(1'b0, 24'sd1001, 1'b0);
        issue(1'b1, 24'h000000, 1'b0);
        issue(1'b0, 24'sd5, 1'b1);
        issue(1'b1, 24'hFFFFFF, 1'b0);
        drain();

        // equal edges, zero bin count
        set_levels(24'sd100, 24'sd100, 6'd0);
        issue(1'b0, 24'sd100, 1'b0);
        issue(1'b0, 24'sd99, 1'b0);
        issue(1'b0, 24'sd101, 1'b0);
        issue(1'b1, 24'h000000, 1'b0);
        drain();

        // reversed edges, bin count above the maximum
        set_levels(24'sd500, -24'sd500, 6'd63);
        issue(1'b0, 24'sd499, 1'b0);
        issue(1'b0, 24'sd500, 1'b0);
        issue(1'b0, -24'sd600, 1'b0);
        issue(1'b0, 24'h7FFFFF, 1'b0);
        issue(1'b1, 24'h000000, 1'b0);
        drain();

        set_levels(24'sh800000, 24'sh7FFFFF, 6'd33);
        issue(1'b0, 24'h800000, 1'b1);
        issue(1'b0, -24'sd1, 1'b0);
        issue(1'b1, 24'h000000, 1'b0);
        drain();

        // shrink the bin count without a clear; upper counters stay hidden
        set_levels(24'sh800000, 24'sh7FFFFF, 6'd2);
        issue(1'b1, 24'h000000, 1'b0);

        repeat (6)
        begin
            drain();
            random_levels();
            gapless = ($urandom_range(0, 3) == 0);
            repeat (39)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    issue(1'b1, SAMPLE_W'($urandom), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    issue(1'b0, draw_sample(), $urandom_range(0, 9) == 0);
                end
            end
            issue(1'b1, 24'h000000, 1'b0);
        end
        drain();

        $display("run drove %0d commands (%0d dumps) over %0d level settings",
                 items_sent, dumps_sent, settings_used);
        $display("%0d dump words compared, %0d mismatches", words_seen, errors);
        if (errors == 0)
        begin
            $display("sample_level_histogram verification clean");
        end
        else
        begin
            $display("sample_level_histogram verification failed");
        end
        $finish;
    end

endmodule
